FILE: src/bcr_pkg.sv
// Package: shared types and constants for the bilinear calibration remap unit.
package bcr_pkg;
  localparam int DefMaxWidth  = 512;
  localparam int DefMaxHeight = 512;
  localparam int DefMaxPlanes = 3;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_PLANES   = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;
  localparam logic [2:0] REG_OFFSET_X = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y = 3'd6;

  localparam logic [59:0] STEP_RESET = 60'd72057662757470208;

  typedef struct packed {
    logic       func;
    logic [8:0] col;
    logic [8:0] row;
    logic [1:0] plane;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       edge_copied;
  } res_t;
endpackage

FILE: src/bcr_regs.sv
// Configuration register file on an APB-style port.
module bcr_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [9:0]  image_width,
  output logic [9:0]  image_height,
  output logic [1:0]  plane_count,
  output logic [59:0] step_x_packed,
  output logic [59:0] step_y_packed,
  output logic [59:0] offset_x_packed,
  output logic [59:0] offset_y_packed
);
  logic [2:0] idx;
  logic       wr;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 10'd512;
      image_height    <= 10'd512;
      plane_count     <= 2'd3;
      step_x_packed   <= bcr_pkg::STEP_RESET;
      step_y_packed   <= bcr_pkg::STEP_RESET;
      offset_x_packed <= '0;
      offset_y_packed <= '0;
    end else if (wr) begin
      unique case (idx)
        bcr_pkg::REG_WIDTH:    image_width     <= pwdata[9:0];
        bcr_pkg::REG_HEIGHT:   image_height    <= pwdata[9:0];
        bcr_pkg::REG_PLANES:   plane_count     <= pwdata[1:0];
        bcr_pkg::REG_STEP_X:   step_x_packed   <= pwdata[59:0];
        bcr_pkg::REG_STEP_Y:   step_y_packed   <= pwdata[59:0];
        bcr_pkg::REG_OFFSET_X: offset_x_packed <= pwdata[59:0];
        bcr_pkg::REG_OFFSET_Y: offset_y_packed <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bcr_pkg::REG_WIDTH:    prdata = {54'd0, image_width};
      bcr_pkg::REG_HEIGHT:   prdata = {54'd0, image_height};
      bcr_pkg::REG_PLANES:   prdata = {62'd0, plane_count};
      bcr_pkg::REG_STEP_X:   prdata = {4'd0, step_x_packed};
      bcr_pkg::REG_STEP_Y:   prdata = {4'd0, step_y_packed};
      bcr_pkg::REG_OFFSET_X: prdata = {4'd0, offset_x_packed};
      bcr_pkg::REG_OFFSET_Y: prdata = {4'd0, offset_y_packed};
      default:               prdata = '0;
    endcase
  end
endmodule

FILE: src/bcr_bank.sv
// One bank of the frame store: one write port, one registered read port.
module bcr_bank #(
  parameter int Depth = 4,
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/bilinear_calibration_remap_unit.sv
// Top level: bilinear calibration remap unit with a four-bank source frame store.
//
// Takes one request per clock (busy is always low) and never stalls. A pixel write
// (func 0) is registered and lands in the store in the following cycle. A remap
// request (func 1) gives its result, if any, on pixel_out/edge_copied with done high
// after these registered steps: coordinate multiply; offset add, split, clamp and
// bank read; first weight products; second weight products; blend sum into the
// output register. The store is split into four banks by row and column parity so
// the four neighbours of a sample are read in the same cycle; a result passes
// through the coordinate multiply, the registered bank read and the two weight
// multiply stages. Writes are delayed so that a write accepted before a request is
// always in the store before that request reads it. There is no clearing pass:
// unwritten pixels read as garbage.
module bilinear_calibration_remap_unit #(
  parameter int MAX_WIDTH  = bcr_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = bcr_pkg::DefMaxHeight,
  parameter int MAX_PLANES = bcr_pkg::DefMaxPlanes
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bcr_pkg::req_t request,
  output logic          done,
  output bcr_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  localparam int HW  = (MAX_WIDTH + 1) / 2;
  localparam int HH  = (MAX_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH * MAX_PLANES;
  localparam int BAW = $clog2(BD);

  logic [9:0]  cfg_w, cfg_h;
  logic [1:0]  cfg_np;
  logic [59:0] sx_p, sy_p, ox_p, oy_p;

  bcr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .image_width(cfg_w), .image_height(cfg_h), .plane_count(cfg_np),
    .step_x_packed(sx_p), .step_y_packed(sy_p),
    .offset_x_packed(ox_p), .offset_y_packed(oy_p)
  );

  assign busy = 1'b0;

  // Effective (clamped) dimensions.
  logic [12:0] w_eff, h_eff;
  logic [1:0]  np_eff;
  always_comb begin
    w_eff = (cfg_w < 10'd2) ? 13'd2 : 13'(cfg_w);
    if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = (cfg_h < 10'd2) ? 13'd2 : 13'(cfg_h);
    if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    np_eff = (cfg_np == 2'd0) ? 2'd1 : cfg_np;
    if (np_eff > 2'(MAX_PLANES)) np_eff = 2'(MAX_PLANES);
  end

  // Bank address of (x, y, plane) for the bank holding that parity.
  function automatic logic [BAW-1:0] baddr(input logic [12:0] x, input logic [12:0] y,
                                           input logic [1:0] p);
    logic [31:0] a;
    a = ((32'(y >> 1) * 32'(HW)) + 32'(x >> 1)) * 32'(MAX_PLANES) + 32'(p);
    return a[BAW-1:0];
  endfunction

  // ---- write path: stage 0 register, stage 1 memory write ----
  logic        wv1;
  logic [1:0]  wbank1;
  logic [BAW-1:0] waddr1;
  logic [7:0]  wdat1;
  always_ff @(posedge clk) begin
    if (rst) wv1 <= 1'b0;
    else wv1 <= start && request.func == bcr_pkg::FUNC_WRITE &&
                32'(request.col) < 32'(MAX_WIDTH) && 32'(request.row) < 32'(MAX_HEIGHT) &&
                32'(request.plane) < 32'(MAX_PLANES);
    wbank1 <= {request.row[0], request.col[0]};
    waddr1 <= baddr(13'(request.col), 13'(request.row), request.plane);
    wdat1  <= request.value;
  end

  // ---- request stage 1: multiply ----
  logic v1;
  logic [1:0] p1;
  logic [28:0] mx1, my1;
  logic signed [19:0] ofx1, ofy1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && request.func == bcr_pkg::FUNC_REQUEST &&
               13'(request.col) < w_eff && 13'(request.row) < h_eff &&
               request.plane < np_eff;
    p1   <= request.plane;
    mx1  <= 29'(request.col) * 29'(sx_p[20*request.plane +: 20]);
    my1  <= 29'(request.row) * 29'(sy_p[20*request.plane +: 20]);
    ofx1 <= ox_p[20*request.plane +: 20];
    ofy1 <= oy_p[20*request.plane +: 20];
  end

  // ---- stage 2: add offset, split, range check, clamp, bank addresses ----
  logic signed [30:0] xs, ys;
  logic signed [14:0] xi, yi;
  logic [15:0] fx, fy;
  logic in_img;
  logic [12:0] cx, cy, cx1, cy1;
  always_comb begin
    xs = 31'(signed'({2'b0, mx1})) + 31'(ofx1);
    ys = 31'(signed'({2'b0, my1})) + 31'(ofy1);
    xi = xs[30:16]; yi = ys[30:16];
    fx = xs[15:0];  fy = ys[15:0];
    in_img = !xi[14] && !yi[14] && (32'(xi) + 1 < 32'(w_eff)) && (32'(yi) + 1 < 32'(h_eff));
    if (xi[14]) cx = '0;
    else if (32'(xi) > 32'(w_eff) - 1) cx = w_eff - 13'd1;
    else cx = xi[12:0];
    if (yi[14]) cy = '0;
    else if (32'(yi) > 32'(h_eff) - 1) cy = h_eff - 13'd1;
    else cy = yi[12:0];
    cx1 = cx + 13'd1;
    cy1 = cy + 13'd1;
  end

  // Bank b = {y parity, x parity}; pick x and y per bank among cx/cx+1, cy/cy+1.
  logic [BAW-1:0] raddr [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [12:0] bx, by;
      bx = (cx[0] == b[0]) ? cx : cx1;
      by = (cy[0] == b[1]) ? cy : cy1;
      raddr[b] = baddr(bx, by, p1);
    end
  end

  logic v2, in2, px2, py2;
  logic [8:0] wx2, wy2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    in2 <= in_img;
    px2 <= cx[0];
    py2 <= cy[0];
    wx2 <= 9'((17'(fx) + 17'd128) >> 8);
    wy2 <= 9'((17'(fy) + 17'd128) >> 8);
  end

  logic [7:0] rd [4];
  for (genvar g = 0; g < 4; g++) begin : g_bank
    bcr_bank #(.Depth(BD), .AW(BAW)) u_bank (
      .clk, .we(wv1 && wbank1 == 2'(g)), .waddr(waddr1), .wdata(wdat1),
      .raddr(raddr[g]), .rdata(rd[g])
    );
  end

  // ---- stage 3: unswizzle neighbours, first weight products ----
  logic [7:0] a00, a01, a10, a11;
  always_comb begin
    a00 = rd[{py2, px2}];
    a01 = rd[{py2, ~px2}];
    a10 = rd[{~py2, px2}];
    a11 = rd[{~py2, ~px2}];
  end
  logic v3, in3;
  logic [7:0] c3;
  logic [16:0] t00, t01, t10, t11;
  logic [8:0] wx3, iwx3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    in3 <= in2;
    c3  <= a00;
    t00 <= 17'(a00) * 17'(9'd256 - wy2);
    t01 <= 17'(a01) * 17'(9'd256 - wy2);
    t10 <= 17'(a10) * 17'(wy2);
    t11 <= 17'(a11) * 17'(wy2);
    wx3 <= wx2;
    iwx3 <= 9'd256 - wx2;
  end

  // ---- stage 4: second weight products ----
  logic v4, in4;
  logic [7:0] c4;
  logic [25:0] u00, u01, u10, u11;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    in4 <= in3;
    c4  <= c3;
    u00 <= 26'(t00) * 26'(iwx3);
    u01 <= 26'(t01) * 26'(wx3);
    u10 <= 26'(t10) * 26'(iwx3);
    u11 <= 26'(t11) * 26'(wx3);
  end

  // ---- stage 5: sum, round, output register ----
  logic [27:0] acc;
  assign acc = 28'(u00) + 28'(u01) + 28'(u10) + 28'(u11) + 28'd32768;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v4;
    result.pixel_out   <= in4 ? acc[23:16] : c4;
    result.edge_copied <= !in4;
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    v1 |-> ##4 done) else $error("result lost");
  a_no_write_result: assert property (@(posedge clk) disable iff (rst)
    wv1 |-> ##4 !done) else $error("write made a result");
  a_weight: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (wx2 <= 9'd256 && wy2 <= 9'd256)) else $error("weight range");
endmodule

FILE: tb/bcr_scoreboard.sv
`timescale 1ns / 1ps
// Checker: tracks the register set and frame store, predicts remap results, compares them.
module bcr_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  bcr_pkg::req_t request,
  input  logic          done,
  input  bcr_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  input  logic          pready,
  output int            fail_count,
  output int            pending
);
  localparam int STORE = bcr_pkg::DefMaxWidth * bcr_pkg::DefMaxHeight *
                         bcr_pkg::DefMaxPlanes;

  logic [7:0]    frame [0:STORE-1];
  logic [9:0]    img_w, img_h;
  logic [1:0]    planes;
  logic [59:0]   step_x, step_y, off_x, off_y;
  bcr_pkg::res_t expected_pixels [$];

  function automatic longint clampi(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned pixel_at(longint x, longint y, int p);
    return 32'(frame[(y * bcr_pkg::DefMaxWidth + x) * bcr_pkg::DefMaxPlanes + p]);
  endfunction

  // Returns 1 and the expected pixel when the request produces a result.
  function automatic bit remap_pixel(bcr_pkg::req_t r, output bcr_pkg::res_t e);
    longint w, h, np, xs, ys, x0, y0;
    logic signed [19:0] ofx, ofy;
    int unsigned fx, fy, wx, wy, acc;
    int p;
    e  = '0;
    p  = int'(r.plane);
    w  = clampi(img_w, 2, bcr_pkg::DefMaxWidth);
    h  = clampi(img_h, 2, bcr_pkg::DefMaxHeight);
    np = clampi(planes, 1, bcr_pkg::DefMaxPlanes);
    if (r.col >= w || r.row >= h || r.plane >= np) return 0;
    ofx = off_x[20*p +: 20];
    ofy = off_y[20*p +: 20];
    xs = longint'(ofx) + longint'(r.col) * longint'(step_x[20*p +: 20]);
    ys = longint'(ofy) + longint'(r.row) * longint'(step_y[20*p +: 20]);
    x0 = xs >>> 16;
    y0 = ys >>> 16;
    fx = 32'(xs[15:0]);
    fy = 32'(ys[15:0]);
    if (x0 >= 0 && x0 + 1 < w && y0 >= 0 && y0 + 1 < h) begin
      wx  = (fx + 128) >> 8;
      wy  = (fy + 128) >> 8;
      acc = pixel_at(x0 + 1, y0 + 1, p) * wy * wx
          + pixel_at(x0 + 1, y0, p) * (256 - wy) * wx
          + pixel_at(x0, y0 + 1, p) * wy * (256 - wx)
          + pixel_at(x0, y0, p) * (256 - wy) * (256 - wx) + 32768;
      e.pixel_out   = acc[23:16];
      e.edge_copied = 1'b0;
    end else begin
      x0 = clampi(x0, 0, w - 1);
      y0 = clampi(y0, 0, h - 1);
      e.pixel_out   = 8'(pixel_at(x0, y0, p));
      e.edge_copied = 1'b1;
    end
    return 1;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    bcr_pkg::res_t e, got;
    if (rst) begin
      img_w <= 10'd512; img_h <= 10'd512; planes <= 2'd3;
      step_x <= bcr_pkg::STEP_RESET; step_y <= bcr_pkg::STEP_RESET;
      off_x <= '0; off_y <= '0;
      expected_pixels.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[5:3])
          bcr_pkg::REG_WIDTH:    img_w  <= pwdata[9:0];
          bcr_pkg::REG_HEIGHT:   img_h  <= pwdata[9:0];
          bcr_pkg::REG_PLANES:   planes <= pwdata[1:0];
          bcr_pkg::REG_STEP_X:   step_x <= pwdata[59:0];
          bcr_pkg::REG_STEP_Y:   step_y <= pwdata[59:0];
          bcr_pkg::REG_OFFSET_X: off_x  <= pwdata[59:0];
          bcr_pkg::REG_OFFSET_Y: off_y  <= pwdata[59:0];
          default: ;
        endcase
      end
      if (done) begin
        got = result;
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (got.pixel_out !== e.pixel_out || got.edge_copied !== e.edge_copied) begin
            if (fail_count < 10)
              $display("mismatch: pixel exp %0d got %0d, edge exp %0b got %0b",
                       e.pixel_out, got.pixel_out, e.edge_copied, got.edge_copied);
            fail_count <= fail_count + 1;
          end
        end
      end
      // prediction uses the store as it stood before this request
      if (start && !busy) begin
        if (request.func == bcr_pkg::FUNC_WRITE) begin
          if (request.plane < bcr_pkg::DefMaxPlanes)
            frame[(request.row * bcr_pkg::DefMaxWidth + request.col) * bcr_pkg::DefMaxPlanes
                  + request.plane] = request.value;
        end else if (remap_pixel(request, e)) begin
          expected_pixels.push_back(e);
        end
      end
    end
  end
endmodule

FILE: tb/bilinear_calibration_remap_unit_test.sv
`timescale 1ns / 1ps
// Testbench top: drives pixel writes, remap requests and register writes.
module bilinear_calibration_remap_unit_test;
  // Square patch of the store filled at start; every read stays inside it.
  localparam int PATCH = 16;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy, done, pready;
  bcr_pkg::req_t request = '0;
  bcr_pkg::res_t result;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]    paddr = '0;
  logic [63:0]   pwdata = '0;
  logic [63:0]   prdata;
  int            fail_count, pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bilinear_calibration_remap_unit dut (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bcr_scoreboard checker_i (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // Hand one request over; start stays high across back-to-back requests.
  task automatic issue(bcr_pkg::req_t r, int gap);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pixel_write(int c, int r, int p, int gap);
    bcr_pkg::req_t q;
    q.func = bcr_pkg::FUNC_WRITE; q.col = 9'(c); q.row = 9'(r); q.plane = 2'(p);
    q.value = 8'($urandom);
    issue(q, gap);
  endtask

  task automatic remap(int c, int r, int p, int gap);
    bcr_pkg::req_t q;
    q.func = bcr_pkg::FUNC_REQUEST; q.col = 9'(c); q.row = 9'(r); q.plane = 2'(p);
    q.value = 8'($urandom);
    issue(q, gap);
  endtask

  // Stop sending and let every outstanding result come back, then wait out writes
  // still in the store pipeline.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(int w, int h, int pc, logic [59:0] sx, logic [59:0] sy,
                           logic [59:0] ox, logic [59:0] oy);
    drain();
    reg_write(bcr_pkg::REG_WIDTH, 64'(w));
    reg_write(bcr_pkg::REG_HEIGHT, 64'(h));
    reg_write(bcr_pkg::REG_PLANES, 64'(pc));
    reg_write(bcr_pkg::REG_STEP_X, 64'(sx));
    reg_write(bcr_pkg::REG_STEP_Y, 64'(sy));
    reg_write(bcr_pkg::REG_OFFSET_X, 64'(ox));
    reg_write(bcr_pkg::REG_OFFSET_Y, 64'(oy));
  endtask

  // Steps: any 20-bit value when the image fits the patch; otherwise small
  // enough that col*step plus the largest offset stays inside the patch.
  function automatic logic [59:0] rand_steps(bit wide_image);
    logic [59:0] v;
    for (int p = 0; p < 3; p++)
      if (wide_image) v[20*p +: 20] = 20'($urandom_range(0, 700));
      else if ($urandom_range(0, 1)) v[20*p +: 20] = 20'($urandom);
      else v[20*p +: 20] = 20'($urandom_range(16'h8000, 20'h18000));
    return v;
  endfunction

  function automatic logic [59:0] rand_lanes();
    return 60'({$urandom, $urandom});
  endfunction

  // One phase of mixed traffic; wide images sweep the whole column/row range.
  task automatic traffic(bit wide_image, int count);
    bit quiet;
    int gap, lim;
    quiet = ($urandom_range(0, 3) == 0);
    lim   = wide_image ? 511 : 31;
    for (int i = 0; i < count; i++) begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 9) < 7)
        remap($urandom_range(0, ($urandom_range(0, 19) == 0) ? 511 : lim),
              $urandom_range(0, ($urandom_range(0, 19) == 0) ? 511 : lim),
              $urandom_range(0, 3), gap);
      else if ($urandom_range(0, 2) == 0)
        pixel_write($urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(0, 3), gap);
      else
        pixel_write($urandom_range(0, PATCH - 1), $urandom_range(0, PATCH - 1),
                    $urandom_range(0, 2), gap);
    end
  endtask

  initial begin
    bit wide;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the patch before any request can read it.
    for (int r = 0; r < PATCH; r++)
      for (int c = 0; c < PATCH; c++)
        for (int p = 0; p < 3; p++)
          pixel_write(c, r, p, 0);

    // Smallest image, largest steps, most negative offsets; plane count 0 clamps to 1.
    configure(2, 2, 0, {3{20'hFFFFF}}, {3{20'hFFFFF}}, {3{20'h80000}}, {3{20'h80000}});
    remap(0, 0, 0, 0);
    remap(1, 1, 0, 3);
    remap(1, 0, 1, 0);
    remap(2, 0, 0, 0);
    pixel_write(511, 511, 2, 1);
    pixel_write(5, 5, 3, 0);
    remap(0, 1, 0, 2);

    // Largest image, zero steps, most positive offsets: interior blends.
    configure(1023, 512, 3, '0, '0, {3{20'h7FFFF}}, {3{20'h7FFFF}});
    remap(0, 0, 0, 0);
    remap(511, 511, 2, 0);
    remap(511, 0, 1, 5);
    remap(0, 511, 3, 0);

    // Unit steps and zero offsets on a patch-sized image: hits right/bottom edges.
    configure(PATCH, PATCH, 3, bcr_pkg::STEP_RESET, bcr_pkg::STEP_RESET, '0, '0);
    remap(0, 0, 0, 0);
    remap(PATCH - 1, PATCH - 1, 2, 0);
    remap(PATCH - 2, PATCH - 2, 1, 0);
    remap(PATCH, 0, 0, 0);

    for (int ph = 0; ph < 9; ph++) begin
      wide = 1'($urandom_range(0, 1));
      if (wide)
        configure($urandom_range(PATCH + 1, 1023), $urandom_range(PATCH + 1, 1023),
                  $urandom_range(0, 3), rand_steps(1), rand_steps(1),
                  rand_lanes(), rand_lanes());
      else
        configure($urandom_range(0, PATCH), $urandom_range(0, PATCH),
                  $urandom_range(0, 3), rand_steps(0), rand_steps(0),
                  rand_lanes(), rand_lanes());
      traffic(wide, 70);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
